FILE: rtl/ocig_pkg.sv
package ocig_pkg;

    // Configuration and sizing constants.
    localparam int MAX_CHUNKS  = 64;
    localparam int COUNT_WIDTH = 32;
    localparam int CFG_W       = 20;
    localparam int STRIDE_W    = 8;
    localparam int OUT_W       = 32;
    localparam int OIDX_W      = 6;

    // Working width: holds the padded total n + (k - 1) * overlap.
    localparam int PAD_W  = CFG_W + $clog2(MAX_CHUNKS);
    localparam int DIV_W  = ((COUNT_WIDTH > PAD_W) ? COUNT_WIDTH : PAD_W) + 1;
    localparam int DVS_W  = CFG_W;
    localparam int K_W    = $clog2(MAX_CHUNKS + 1);
    localparam int IDX_W  = $clog2(MAX_CHUNKS);
    localparam int CNT_W  = $clog2(DIV_W + 1);

    typedef logic [DIV_W-1:0]    t_word;
    typedef logic [DVS_W-1:0]    t_dvs;
    typedef logic [CFG_W-1:0]    t_cfg;
    typedef logic [STRIDE_W-1:0] t_stride;
    typedef logic [K_W-1:0]      t_k;
    typedef logic [IDX_W-1:0]    t_idx;
    typedef logic [OUT_W-1:0]    t_out;
    typedef logic [OIDX_W-1:0]   t_oidx;
    typedef logic [CNT_W-1:0]    t_cnt;
    typedef logic [1:0]          t_cfg_addr;

    // Register indexes on the configuration port.
    localparam t_cfg_addr CFG_CHUNK_SIZE = 2'd0;
    localparam t_cfg_addr CFG_STRIDE     = 2'd1;
    localparam t_cfg_addr CFG_OVERLAP    = 2'd2;

    // Reset values of the configuration registers.
    localparam t_cfg    RST_CHUNK_SIZE = 20'd10000;
    localparam t_stride RST_STRIDE     = 8'd5;
    localparam t_cfg    RST_OVERLAP    = 20'd500;

    typedef enum logic [2:0] {
        STAT_OK        = 3'd0,
        STAT_EMPTY     = 3'd1,
        STAT_BAD_STRIDE = 3'd2,
        STAT_BAD_CHUNK = 3'd3,
        STAT_BAD_OVL   = 3'd4,
        STAT_TOO_MANY  = 3'd5
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHK,
        S_DIV,
        S_TOT,
        S_CHUNK,
        S_END,
        S_EMIT,
        S_ERR
    } t_state;

    // What the pending division is for.
    typedef enum logic [2:0] {
        OP_CS,
        OP_OV,
        OP_K,
        OP_TOT,
        OP_S,
        OP_E
    } t_op;

    typedef struct packed {
        logic  start;
        t_word dividend;
        t_dvs  divisor;
    } t_div_req;

    typedef struct packed {
        logic  done;
        t_word quo;
        t_dvs  rem;
    } t_div_rsp;

endpackage

FILE: rtl/ocig_div.sv
// Restoring divider, one quotient bit per cycle.
// The response's done pulses once the last quotient bit is in; quotient and
// remainder then hold until the next start. The divisor must be nonzero.
module ocig_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ocig_pkg::t_div_req i_req,
    output ocig_pkg::t_div_rsp o_rsp
);

    logic               r_busy;
    logic               r_done;
    ocig_pkg::t_cnt     r_cnt;
    ocig_pkg::t_word    r_quo;
    ocig_pkg::t_dvs     r_rem;
    ocig_pkg::t_dvs     r_dvs;

    logic [ocig_pkg::DVS_W:0] w_trial;
    logic [ocig_pkg::DVS_W:0] w_diff;
    logic                     w_ge;

    // Shift in the next dividend bit and try a subtraction.
    always_comb begin
        w_trial = {r_rem, r_quo[ocig_pkg::DIV_W-1]};
        w_diff  = w_trial - {1'b0, r_dvs};
        w_ge    = (w_trial >= {1'b0, r_dvs});
    end

    // Control: busy flag, step counter and done pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= ocig_pkg::t_cnt'(ocig_pkg::DIV_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - ocig_pkg::t_cnt'(1);
                if (r_cnt == ocig_pkg::t_cnt'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: partial remainder and quotient shift register.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[ocig_pkg::DVS_W-1:0] : w_trial[ocig_pkg::DVS_W-1:0];
            r_quo <= {r_quo[ocig_pkg::DIV_W-2:0], w_ge};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;
    assign o_rsp.rem  = r_rem;

endmodule

FILE: rtl/overlapped_chunk_interval_generator.sv
// Splits a read of i_sample_count samples into overlapping chunks.
// Input channel: i_valid / o_stall; a request is taken when i_valid is high
// and o_stall is low. o_stall stays high from acceptance until the last
// result of that request has been handed to the output register.
// Output channel: o_valid / i_stall; one result per chunk with status, start,
// end (exclusive), index and last. A failed check gives one result with a
// nonzero status, zero fields and last set.
// Configuration: i_cfg_we writes i_cfg_wdata into register i_cfg_addr
// (0 chunk size, 1 stride, 2 overlap); index 3 is ignored.
// Divisions: all go through one shared one-bit-per-cycle divider. A request
// runs the two config modulo checks, the chunk-count division (only when the
// count exceeds the chunk size) and the total / k division, then per chunk a
// start modulo (not for the first) and an end modulo (not for the last).
// Reset returns the sequencer to idle, drops o_valid and loads the register
// defaults (10000, 5, 500). When the receiver stalls, the result waits in the
// output register and the sequencer holds before loading the next one.
module overlapped_chunk_interval_generator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_sample_count,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_status,
    output logic [31:0] o_chunk_start,
    output logic [31:0] o_chunk_end,
    output logic [5:0]  o_chunk_index,
    output logic        o_last,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [19:0] i_cfg_wdata
);

    // Configuration registers.
    ocig_pkg::t_cfg    r_cs;
    ocig_pkg::t_stride r_stride;
    ocig_pkg::t_cfg    r_ov;

    // Sequencer state and working registers.
    ocig_pkg::t_state  r_state, n_state;
    ocig_pkg::t_op     r_op, n_op;
    ocig_pkg::t_status r_err, n_err;
    ocig_pkg::t_word   r_n, n_n;
    ocig_pkg::t_k      r_k, n_k;
    ocig_pkg::t_word   r_q, n_q;
    ocig_pkg::t_k      r_longer, n_longer;
    ocig_pkg::t_idx    r_idx, n_idx;
    ocig_pkg::t_word   r_raw_start, n_raw_start;
    ocig_pkg::t_word   r_raw_end, n_raw_end;
    ocig_pkg::t_word   r_s, n_s;
    ocig_pkg::t_word   r_e, n_e;

    // Output register.
    logic              r_ovalid, n_ovalid;
    ocig_pkg::t_status r_ostatus, n_ostatus;
    ocig_pkg::t_out    r_ostart, n_ostart;
    ocig_pkg::t_out    r_oend, n_oend;
    ocig_pkg::t_oidx   r_oidx, n_oidx;
    logic              r_olast, n_olast;

    ocig_pkg::t_div_req w_req;
    ocig_pkg::t_div_rsp w_rsp;
    ocig_pkg::t_dvs     w_step;
    ocig_pkg::t_word    w_raw_end;
    logic               w_load_ok;
    logic               w_is_last;

    ocig_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cs     <= ocig_pkg::RST_CHUNK_SIZE;
            r_stride <= ocig_pkg::RST_STRIDE;
            r_ov     <= ocig_pkg::RST_OVERLAP;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                ocig_pkg::CFG_CHUNK_SIZE: r_cs     <= i_cfg_wdata;
                ocig_pkg::CFG_STRIDE:     r_stride <= i_cfg_wdata[ocig_pkg::STRIDE_W-1:0];
                ocig_pkg::CFG_OVERLAP:    r_ov     <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Helpers shared by several states.
    always_comb begin
        w_step    = r_cs - r_ov;
        w_raw_end = r_raw_start + r_q
                  + ocig_pkg::t_word'(ocig_pkg::t_k'(r_idx) < r_longer);
        w_load_ok = !r_ovalid || !i_stall;
        w_is_last = (ocig_pkg::t_k'(r_idx) + ocig_pkg::t_k'(1)) == r_k;
    end

    // Sequencer: next state, divider requests and output loads.
    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_err       = r_err;
        n_n         = r_n;
        n_k         = r_k;
        n_q         = r_q;
        n_longer    = r_longer;
        n_idx       = r_idx;
        n_raw_start = r_raw_start;
        n_raw_end   = r_raw_end;
        n_s         = r_s;
        n_e         = r_e;
        n_ovalid    = r_ovalid && i_stall;
        n_ostatus   = r_ostatus;
        n_ostart    = r_ostart;
        n_oend      = r_oend;
        n_oidx      = r_oidx;
        n_olast     = r_olast;
        w_req.start    = 1'b0;
        w_req.dividend = r_raw_start;
        w_req.divisor  = ocig_pkg::t_dvs'(r_stride);

        unique case (r_state)
            ocig_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_n = ocig_pkg::t_word'(i_sample_count)
                        & ((ocig_pkg::t_word'(1) << ocig_pkg::COUNT_WIDTH)
                           - ocig_pkg::t_word'(1));
                    n_state = ocig_pkg::S_CHK;
                end
            end
            ocig_pkg::S_CHK: begin
                priority if (r_n == '0) begin
                    n_err   = ocig_pkg::STAT_EMPTY;
                    n_state = ocig_pkg::S_ERR;
                end else if (r_stride == '0) begin
                    n_err   = ocig_pkg::STAT_BAD_STRIDE;
                    n_state = ocig_pkg::S_ERR;
                end else if (r_cs == '0 || r_cs == ocig_pkg::t_cfg'(r_stride)
                             || r_cs <= r_ov) begin
                    n_err   = ocig_pkg::STAT_BAD_CHUNK;
                    n_state = ocig_pkg::S_ERR;
                end else begin
                    w_req.start    = 1'b1;
                    w_req.dividend = ocig_pkg::t_word'(r_cs);
                    n_op           = ocig_pkg::OP_CS;
                    n_state        = ocig_pkg::S_DIV;
                end
            end
            ocig_pkg::S_DIV: begin
                if (w_rsp.done) begin
                    unique case (r_op)
                        ocig_pkg::OP_CS: begin
                            if (w_rsp.rem != '0) begin
                                n_err   = ocig_pkg::STAT_BAD_CHUNK;
                                n_state = ocig_pkg::S_ERR;
                            end else begin
                                w_req.start    = 1'b1;
                                w_req.dividend = ocig_pkg::t_word'(r_ov);
                                n_op           = ocig_pkg::OP_OV;
                            end
                        end
                        ocig_pkg::OP_OV: begin
                            if (w_rsp.rem != '0
                                || (r_stride != ocig_pkg::t_stride'(1) && r_ov == '0)) begin
                                n_err   = ocig_pkg::STAT_BAD_OVL;
                                n_state = ocig_pkg::S_ERR;
                            end else if (r_n > ocig_pkg::t_word'(r_cs)) begin
                                // Ceiling of the remaining samples over the step.
                                w_req.start    = 1'b1;
                                w_req.dividend = r_n - ocig_pkg::t_word'(r_cs)
                                               + ocig_pkg::t_word'(w_step)
                                               - ocig_pkg::t_word'(1);
                                w_req.divisor  = w_step;
                                n_op           = ocig_pkg::OP_K;
                            end else begin
                                n_k     = ocig_pkg::t_k'(1);
                                n_state = ocig_pkg::S_TOT;
                            end
                        end
                        ocig_pkg::OP_K: begin
                            if (w_rsp.quo >= ocig_pkg::t_word'(ocig_pkg::MAX_CHUNKS)) begin
                                n_err   = ocig_pkg::STAT_TOO_MANY;
                                n_state = ocig_pkg::S_ERR;
                            end else begin
                                n_k     = w_rsp.quo[ocig_pkg::K_W-1:0] + ocig_pkg::t_k'(1);
                                n_state = ocig_pkg::S_TOT;
                            end
                        end
                        ocig_pkg::OP_TOT: begin
                            n_q         = w_rsp.quo;
                            n_longer    = w_rsp.rem[ocig_pkg::K_W-1:0];
                            n_idx       = '0;
                            n_raw_start = '0;
                            n_state     = ocig_pkg::S_CHUNK;
                        end
                        ocig_pkg::OP_S: begin
                            // Round the start up to the stride.
                            if (w_rsp.rem != '0) begin
                                n_s = r_s + ocig_pkg::t_word'(r_stride)
                                    - ocig_pkg::t_word'(w_rsp.rem);
                            end
                            n_state = ocig_pkg::S_END;
                        end
                        ocig_pkg::OP_E: begin
                            // Round the end down to the stride.
                            n_e     = r_e - ocig_pkg::t_word'(w_rsp.rem);
                            n_state = ocig_pkg::S_EMIT;
                        end
                        default: ;
                    endcase
                end
            end
            ocig_pkg::S_TOT: begin
                // Padded total split over k chunks.
                w_req.start    = 1'b1;
                w_req.dividend = r_n + ocig_pkg::t_word'(r_k - ocig_pkg::t_k'(1))
                               * ocig_pkg::t_word'(r_ov);
                w_req.divisor  = ocig_pkg::t_dvs'(r_k);
                n_op           = ocig_pkg::OP_TOT;
                n_state        = ocig_pkg::S_DIV;
            end
            ocig_pkg::S_CHUNK: begin
                n_raw_end = w_raw_end;
                n_s       = r_raw_start;
                n_e       = w_raw_end;
                if (r_idx != '0) begin
                    w_req.start    = 1'b1;
                    w_req.dividend = r_raw_start;
                    n_op           = ocig_pkg::OP_S;
                    n_state        = ocig_pkg::S_DIV;
                end else begin
                    n_state = ocig_pkg::S_END;
                end
            end
            ocig_pkg::S_END: begin
                if (!w_is_last) begin
                    w_req.start    = 1'b1;
                    w_req.dividend = r_e;
                    n_op           = ocig_pkg::OP_E;
                    n_state        = ocig_pkg::S_DIV;
                end else begin
                    n_state = ocig_pkg::S_EMIT;
                end
            end
            ocig_pkg::S_EMIT: begin
                if (w_load_ok) begin
                    n_ovalid  = 1'b1;
                    n_ostatus = ocig_pkg::STAT_OK;
                    n_ostart  = ocig_pkg::t_out'(r_s);
                    n_oend    = ocig_pkg::t_out'(r_e);
                    n_oidx    = ocig_pkg::t_oidx'(r_idx);
                    n_olast   = w_is_last;
                    if (w_is_last) begin
                        n_state = ocig_pkg::S_IDLE;
                    end else begin
                        // Next raw start steps back by the overlap, floored at zero.
                        n_raw_start = (r_raw_end >= ocig_pkg::t_word'(r_ov))
                                    ? r_raw_end - ocig_pkg::t_word'(r_ov) : '0;
                        n_idx   = r_idx + ocig_pkg::t_idx'(1);
                        n_state = ocig_pkg::S_CHUNK;
                    end
                end
            end
            ocig_pkg::S_ERR: begin
                if (w_load_ok) begin
                    n_ovalid  = 1'b1;
                    n_ostatus = r_err;
                    n_ostart  = '0;
                    n_oend    = '0;
                    n_oidx    = '0;
                    n_olast   = 1'b1;
                    n_state   = ocig_pkg::S_IDLE;
                end
            end
            default: n_state = ocig_pkg::S_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ocig_pkg::S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    // Working and output payload registers.
    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_err       <= n_err;
        r_n         <= n_n;
        r_k         <= n_k;
        r_q         <= n_q;
        r_longer    <= n_longer;
        r_idx       <= n_idx;
        r_raw_start <= n_raw_start;
        r_raw_end   <= n_raw_end;
        r_s         <= n_s;
        r_e         <= n_e;
        r_ostatus   <= n_ostatus;
        r_ostart    <= n_ostart;
        r_oend      <= n_oend;
        r_oidx      <= n_oidx;
        r_olast     <= n_olast;
    end

    assign o_stall       = (r_state != ocig_pkg::S_IDLE);
    assign o_valid       = r_ovalid;
    assign o_status      = r_ostatus;
    assign o_chunk_start = r_ostart;
    assign o_chunk_end   = r_oend;
    assign o_chunk_index = r_oidx;
    assign o_last        = r_olast;

    // An accepted request always starts with the configuration checks.
    a_accept_to_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> (r_state == ocig_pkg::S_CHK))
        else $error("accepted request did not enter the check state");

    // Error results are single, last, and carry zero fields.
    a_error_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ocig_pkg::STAT_OK) |->
        (o_last && o_chunk_index == '0 && o_chunk_start == '0 && o_chunk_end == '0))
        else $error("error result with nonzero fields or without last");

    // The chunk counter never runs past the chunk count.
    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ocig_pkg::S_CHUNK) |-> (ocig_pkg::t_k'(r_idx) < r_k))
        else $error("chunk index beyond chunk count");

endmodule

FILE: verif/overlapped_chunk_interval_generator_test.sv
`timescale 1ns / 100ps

module overlapped_chunk_interval_generator_test;
    import ocig_pkg::*;

    // Register index past the end of the list; writes to it are dropped.
    localparam t_cfg_addr CFG_UNUSED = 2'd3;

    localparam int      N_DIRECTED   = 40;
    localparam int      N_PHASES     = 12;
    localparam int      PHASE_ITEMS  = 42;
    localparam int      SETTLE       = 8;
    localparam int      TAIL         = 200;
    localparam int      LONG_IDLE    = 60;
    localparam longint  CYCLE_LIMIT  =
        4 * 600 * (MAX_CHUNKS * (80 + LONG_IDLE) + LONG_IDLE + 50);

    // One chunk as the block reports it.
    typedef struct packed {
        t_status status;
        t_out    start_pos;
        t_out    end_pos;
        t_oidx   index;
        logic    last;
    } chunk_rec_t;

    // One row of the directed stimulus: a register write or a request.
    typedef struct packed {
        logic      is_write;
        t_cfg_addr addr;
        t_out      value;
        logic      has_result;
        t_status   status;
        t_out      start_pos;
        t_out      end_pos;
    } stim_row_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [31:0] i_sample_count = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [2:0]  o_status;
    logic [31:0] o_chunk_start;
    logic [31:0] o_chunk_end;
    logic [5:0]  o_chunk_index;
    logic        o_last;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_addr = '0;
    logic [19:0] i_cfg_wdata = '0;

    // Shadow copy of the configuration registers.
    t_cfg    chunk_len = RST_CHUNK_SIZE;
    t_stride align     = RST_STRIDE;
    t_cfg    shared    = RST_OVERLAP;

    chunk_rec_t  pending_chunks[$];
    chunk_rec_t  got_rec;
    int unsigned mismatches = 0;
    longint      cycles = 0;
    bit          idle_on = 1'b1;
    int unsigned stall_left = 0;
    int unsigned stall_hold;

    stim_row_t directed_rows [N_DIRECTED] = '{
        '{1'b0, CFG_UNUSED, 32'd10000, 1'b1, STAT_OK, 32'd0, 32'd10000},
        '{1'b0, CFG_UNUSED, 32'd0, 1'b1, STAT_EMPTY, 32'd0, 32'd0},
        '{1'b0, CFG_UNUSED, 32'd1, 1'b1, STAT_OK, 32'd0, 32'd1},
        '{1'b0, CFG_UNUSED, 32'd10001, 1'b0, STAT_OK, 32'd0, 32'd0},
        '{1'b0, CFG_UNUSED, 32'd608500, 1'b0, STAT_OK, 32'd0, 32'd0},
        '{1'b0, CFG_UNUSED, 32'd608501, 1'b1, STAT_TOO_MANY, 32'd0, 32'd0},
        '{1'b0, CFG_UNUSED, 32'hFFFFFFFF, 1'b1, STAT_TOO_MANY, 32'd0, 32'd0},
        '{1'b1, CFG_UNUSED, 32'd1, 1'b0, STAT_OK, 32'd0, 32'd0},
        '{1'b0, CFG_UNUSED, 32'd10000, 1'b1, STAT_OK, 32'd0, 32'd10000},
        '{1'b1, CFG_CHUNK_SIZE, 32'd1048575, 1'b0, STAT_OK, 32'd0, 32'd0},
        '{1'b1, CFG_STRIDE, 32'd1, 1'b0, STAT_OK, 32'd0, 32'd0},
        '{1'b1, CFG_OVERLAP, 32'd0, 1'b0, STAT_OK, 32'd0, 32'd0},
        '{1'b0, CFG_UNUSED, 32'd1048575, 1'b1, STAT_OK, 32'd0, 32'd1048575},
        '{1'b0, CFG_UNUSED, 32'd67108800, 1'b0, STAT_OK, 32'd0, 32'd0},
        '{1'b0, CFG_UNUSED, 32'hFFFFFFFF, 1'b1, STAT_TOO_MANY, 32'd0, 32'd0},
        '{1'b1, CFG_STRIDE, 32'd255, 1'b0, STAT_OK, 32'd0, 32'd0},
        '{1'b0, CFG_UNUSED, 32'd5, 1'b1, STAT_BAD_CHUNK, 32'd0, 32'd0},
        '{1'b1, CFG_CHUNK_SIZE, 32'd510, 1'b0, STAT_OK, 32'd0, 32'd0},
        '{1'b0, CFG_UNUSED, 32'd5, 1'b1, STAT_BAD_OVL, 32'd0, 32'd0},
        '{1'b1, CFG_OVERLAP, 32'd255, 1'b0, STAT_OK, 32'd0, 32'd0},
        '{1'b0, CFG_UNUSED, 32'd1000, 1'b0, STAT_OK, 32'd0, 32'd0},
        '{1'b0, CFG_UNUSED, 32'd510, 1'b1, STAT_OK, 32'd0, 32'd510},
        '{1'b1, CFG_STRIDE, 32'd0, 1'b0, STAT_OK, 32'd0, 32'd0},
        '{1'b0, CFG_UNUSED, 32'd7, 1'b1, STAT_BAD_STRIDE, 32'd0, 32'd0},
        '{1'b1, CFG_STRIDE, 32'd10, 1'b0, STAT_OK, 32'd0, 32'd0},
        '{1'b1, CFG_CHUNK_SIZE, 32'd100, 1'b0, STAT_OK, 32'd0, 32'd0},
        '{1'b1, CFG_OVERLAP, 32'd25, 1'b0, STAT_OK, 32'd0, 32'd0},
        '{1'b0, CFG_UNUSED, 32'd50, 1'b1, STAT_BAD_OVL, 32'd0, 32'd0},
        '{1'b1, CFG_OVERLAP, 32'd100, 1'b0, STAT_OK, 32'd0, 32'd0},
        '{1'b0, CFG_UNUSED, 32'd50, 1'b1, STAT_BAD_CHUNK, 32'd0, 32'd0},
        '{1'b1, CFG_OVERLAP, 32'd0, 1'b0, STAT_OK, 32'd0, 32'd0},
        '{1'b1, CFG_CHUNK_SIZE, 32'd10, 1'b0, STAT_OK, 32'd0, 32'd0},
        '{1'b0, CFG_UNUSED, 32'd50, 1'b1, STAT_BAD_CHUNK, 32'd0, 32'd0},
        '{1'b1, CFG_STRIDE, 32'd3, 1'b0, STAT_OK, 32'd0, 32'd0},
        '{1'b1, CFG_CHUNK_SIZE, 32'd1048575, 1'b0, STAT_OK, 32'd0, 32'd0},
        '{1'b1, CFG_OVERLAP, 32'd1048575, 1'b0, STAT_OK, 32'd0, 32'd0},
        '{1'b0, CFG_UNUSED, 32'd100, 1'b1, STAT_BAD_CHUNK, 32'd0, 32'd0},
        '{1'b1, CFG_OVERLAP, 32'd1048572, 1'b0, STAT_OK, 32'd0, 32'd0},
        '{1'b0, CFG_UNUSED, 32'd1048725, 1'b0, STAT_OK, 32'd0, 32'd0},
        '{1'b0, CFG_UNUSED, 32'h80000000, 1'b1, STAT_TOO_MANY, 32'd0, 32'd0}
    };

    overlapped_chunk_interval_generator DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_sample_count (i_sample_count),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_status       (o_status),
        .o_chunk_start  (o_chunk_start),
        .o_chunk_end    (o_chunk_end),
        .o_chunk_index  (o_chunk_index),
        .o_last         (o_last),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_wdata    (i_cfg_wdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Idle length: mostly none or short, now and then a long one.
    function automatic int unsigned idle_len();
        int unsigned r;
        if (!idle_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 4);
        return $urandom_range(20, LONG_IDLE);
    endfunction

    // Work out the chunks of one request from the shadow registers and queue them.
    function automatic void predict_chunks(input logic [31:0] count);
        longint unsigned n, k, step, total, q, longer, raw_start, raw_end, s, e, i;
        t_status    st;
        chunk_rec_t rec;
        n  = count;
        st = STAT_OK;
        if (n == 0)
            st = STAT_EMPTY;
        else if (align == 0)
            st = STAT_BAD_STRIDE;
        else if (chunk_len == 0 || (chunk_len % align) != 0 || chunk_len == align ||
                 chunk_len <= shared)
            st = STAT_BAD_CHUNK;
        else if ((shared % align) != 0 || (align != 1 && shared == 0))
            st = STAT_BAD_OVL;
        k = 1;
        if (st == STAT_OK && n > chunk_len) begin
            step = chunk_len - shared;
            k = k + (n - chunk_len + step - 1) / step;
        end
        if (st == STAT_OK && k > MAX_CHUNKS)
            st = STAT_TOO_MANY;
        if (st != STAT_OK) begin
            rec = '{st, '0, '0, '0, 1'b1};
            pending_chunks.push_back(rec);
            return;
        end
        total  = n + (k - 1) * shared;
        q      = total / k;
        longer = total % k;
        raw_start = 0;
        for (i = 0; i < k; i++) begin
            raw_end = raw_start + q + ((i < longer) ? 1 : 0);
            s = raw_start;
            e = raw_end;
            // Interior boundaries snap inward to the stride grid.
            if (i > 0 && (s % align) != 0)
                s = s + align - (s % align);
            if (i + 1 < k)
                e = e - (e % align);
            rec = '{STAT_OK, t_out'(s), t_out'(e), t_oidx'(i), (i + 1 == k)};
            pending_chunks.push_back(rec);
            raw_start = (raw_end >= shared) ? raw_end - shared : 0;
        end
    endfunction

    // Sample count for a random request, aimed mostly at a chosen chunk count.
    function automatic logic [31:0] pick_count();
        int unsigned     r, want;
        longint unsigned step, n;
        r = $urandom_range(0, 99);
        if (r < 5) return '0;
        if (r < 12 || chunk_len <= shared) return $urandom;
        if (r < 22) return $urandom_range(1, chunk_len);
        step = chunk_len - shared;
        want = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 66) : $urandom_range(2, 8);
        n = chunk_len + (want - 2) * step + $urandom_range(1, 32'(step));
        if (n > 64'hFFFFFFFF) n = 64'hFFFFFFFF;
        return n[31:0];
    endfunction

    function automatic void log_mismatch(input string what);
        mismatches++;
        if (mismatches <= 10) $display("%s", what);
    endfunction

    // Hold off new requests until every queued chunk has come back.
    task automatic wait_for_drain();
        i_valid <= 1'b0;
        while (pending_chunks.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_addr addr, input t_cfg value);
        wait_for_drain();
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        case (addr)
            CFG_CHUNK_SIZE: chunk_len = value;
            CFG_STRIDE:     align = value[STRIDE_W-1:0];
            CFG_OVERLAP:    shared = value;
            default: ;
        endcase
        i_cfg_we <= 1'b0;
    endtask

    // Present one request and return at the edge where it is taken.
    task automatic send_count(input logic [31:0] count);
        int unsigned gap;
        gap = idle_len();
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_sample_count <= count;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    // Receiver back-pressure in bursts.
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end else begin
            stall_hold = idle_len();
            i_stall    <= (stall_hold != 0);
            stall_left <= (stall_hold != 0) ? stall_hold - 1 : $urandom_range(0, 5);
        end
    end

    // Compare every accepted chunk with the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_chunks.size() == 0) begin
                log_mismatch($sformatf(
                    "unexpected chunk: status=%0d start=%0d end=%0d index=%0d last=%0b",
                    o_status, o_chunk_start, o_chunk_end, o_chunk_index, o_last));
            end else begin
                got_rec = pending_chunks.pop_front();
                if (o_status !== got_rec.status || o_chunk_start !== got_rec.start_pos ||
                    o_chunk_end !== got_rec.end_pos || o_chunk_index !== got_rec.index ||
                    o_last !== got_rec.last) begin
                    log_mismatch($sformatf(
                        {"chunk mismatch: exp status=%0d start=%0d end=%0d index=%0d ",
                         "last=%0b, got status=%0d start=%0d end=%0d index=%0d last=%0b"},
                        got_rec.status, got_rec.start_pos, got_rec.end_pos,
                        got_rec.index, got_rec.last, o_status, o_chunk_start,
                        o_chunk_end, o_chunk_index, o_last));
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        int unsigned new_stride, new_chunk, new_ovl, m;
        logic [31:0] count;
        chunk_rec_t  rec;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed rows: reset values, extremes and every error code.
        for (int r = 0; r < N_DIRECTED; r++) begin
            if (directed_rows[r].is_write) begin
                write_reg(directed_rows[r].addr, t_cfg'(directed_rows[r].value));
            end else begin
                send_count(directed_rows[r].value);
                if (directed_rows[r].has_result) begin
                    rec = '{directed_rows[r].status, directed_rows[r].start_pos,
                            directed_rows[r].end_pos, '0, 1'b1};
                    pending_chunks.push_back(rec);
                end else begin
                    predict_chunks(directed_rows[r].value);
                end
            end
        end

        // Random phases, each with its own register setting.
        for (int p = 0; p < N_PHASES; p++) begin
            case ($urandom_range(0, 9))
                0: begin
                    // Largest chunk size with an odd stride that divides it.
                    case ($urandom_range(0, 5))
                        0: new_stride = 1;
                        1: new_stride = 3;
                        2: new_stride = 5;
                        3: new_stride = 15;
                        4: new_stride = 25;
                        default: new_stride = 75;
                    endcase
                    new_chunk = 1048575;
                    m = new_chunk / new_stride;
                    new_ovl = new_stride * $urandom_range((new_stride == 1) ? 0 : 1, m - 1);
                end
                1: begin
                    // Arbitrary values; most of these fail the checks.
                    new_chunk  = $urandom;
                    new_stride = $urandom;
                    new_ovl    = $urandom;
                end
                default: begin
                    new_stride = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(1, 255);
                    m = $urandom_range(2, 40);
                    new_chunk = new_stride * m;
                    new_ovl = new_stride * $urandom_range((new_stride == 1) ? 0 : 1, m - 1);
                end
            endcase
            write_reg(CFG_STRIDE, t_cfg'(new_stride & 32'hFF));
            write_reg(CFG_CHUNK_SIZE, t_cfg'(new_chunk));
            write_reg(CFG_OVERLAP, t_cfg'(new_ovl));
            idle_on = ((p % 4) != 1);
            for (int j = 0; j < PHASE_ITEMS; j++) begin
                if (p == 2 && j == PHASE_ITEMS / 2)
                    wait_for_drain();
                count = pick_count();
                send_count(count);
                predict_chunks(count);
            end
        end

        wait_for_drain();
        repeat (TAIL) @(posedge i_clk);
        if (mismatches == 0 && pending_chunks.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

FILE: files.f
rtl/ocig_pkg.sv
rtl/ocig_div.sv
rtl/overlapped_chunk_interval_generator.sv
verif/overlapped_chunk_interval_generator_test.sv
